// ===== design/tmfs_pkg.sv =====
// package for the tracker module format sniffer
// holds the signature tables, offsets and item types; depends on nothing
package tmfs_pkg;

  localparam int PosW         = 11;
  localparam int PosLimit     = 1084;
  localparam int TailStart    = 1080;
  localparam int ScreamOffset = 44;
  localparam int VersionOffset = 29;
  localparam int ShortSigLen  = 4;
  localparam int ExtSigLen    = 17;
  localparam int MaxChannels  = 32;
  localparam logic [7:0] VersionValue = 8'h10;

  // bit positions in the prefix match flags
  localparam int FlagImpulse = 0;
  localparam int FlagExtended = 1;
  localparam int FlagMulti = 2;
  localparam int FlagScream = 3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  function automatic logic [7:0] impulse_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = "I";
      2'd1: r = "M";
      2'd2: r = "P";
      default: r = "M";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] multi_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = "M";
      2'd1: r = "T";
      2'd2: r = "M";
      default: r = 8'h10;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] scream_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = "S";
      2'd1: r = "C";
      2'd2: r = "R";
      default: r = "M";
    endcase
    return r;
  endfunction

  // "Extended Module: "
  function automatic logic [7:0] ext_byte(input logic [4:0] idx);
    logic [7:0] r;
    unique case (idx)
      5'd0: r = "E";
      5'd1: r = "x";
      5'd2: r = "t";
      5'd3: r = "e";
      5'd4: r = "n";
      5'd5: r = "d";
      5'd6: r = "e";
      5'd7: r = "d";
      5'd8: r = " ";
      5'd9: r = "M";
      5'd10: r = "o";
      5'd11: r = "d";
      5'd12: r = "u";
      5'd13: r = "l";
      5'd14: r = "e";
      5'd15: r = ":";
      default: r = " ";
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

endpackage

// ===== design/tmfs_if.sv =====
// valid/ready channel interfaces for the sniffer's input and result words
// depends on nothing
interface tmfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface tmfs_out_if;
  logic valid;
  logic ready;
  logic identified;

  modport source (output valid, output identified, input ready);
  modport sink (input valid, input identified, output ready);
endinterface

// ===== design/tracker_module_format_sniffer.sv =====
// top level of the tracker module format sniffer
// depends on tmfs_pkg and the channel interfaces in tmfs_if.sv

// Takes a file one byte word per cycle, offset 0 first, and on the word marked
// as the last byte returns one result word: identified is 1 if the file holds
// an impulse ("IMPM"), extended ("Extended Module: "), multitracker ("MTM"
// 0x10), scream ("SCRM" at 44 with byte 29 equal to 0x10) or protracker
// (channel tag at 1080..1083) signature. Unmarked bytes give no result. A
// word goes into an input register; from there the position counter, match
// flags and the four-byte tail window update and a result goes into the
// output register. Throughput is one byte per cycle; the only stall is a last
// byte sitting in the input register while an earlier result still waits to
// be taken. After each last byte the counter, match flags and version flag
// return to reset, so the next byte starts a new file. Bytes past offset
// 1083 are ignored.
module tracker_module_format_sniffer import tmfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmfs_in_if.sink    in_i,
  tmfs_out_if.source out_o
);

  // input register
  logic     s1_valid_q;
  in_item_t s1_item_q;

  // per-file state
  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      flags_q, flags_d;
  logic            ver_q, ver_d;
  logic [7:0]      tail_q [4];
  logic [7:0]      tail_d [4];

  // result register
  logic out_valid_q;
  logic out_ident_q;

  logic out_free;
  logic s1_adv;
  logic in_ready;
  logic in_range;
  logic tail_wr;
  logic [1:0] idx;
  logic [7:0] b;
  logic hit;
  logic tail_hit;
  logic [6:0] chan_cnt;

  // handshake: the input register empties unless a last byte waits on a full output
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && (!s1_item_q.last_byte || out_free);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_item_q.byte_value <= in_i.byte_value;
      s1_item_q.last_byte  <= in_i.last_byte;
    end
  end

  // per-byte update of counter, flags and tail window
  assign b        = s1_item_q.byte_value;
  assign idx      = pos_q[1:0];  // tail and scream offsets are multiples of four
  assign in_range = pos_q < PosW'(PosLimit);
  assign tail_wr  = in_range && (pos_q >= PosW'(TailStart));

  always_comb begin
    flags_d = flags_q;
    ver_d   = ver_q;
    pos_d   = pos_q;
    tail_d  = tail_q;
    if (in_range) begin
      if (pos_q < PosW'(ShortSigLen)) begin
        if (b != impulse_byte(idx)) flags_d[FlagImpulse] = 1'b0;
        if (b != multi_byte(idx))   flags_d[FlagMulti] = 1'b0;
      end
      if ((pos_q < PosW'(ExtSigLen)) && (b != ext_byte(pos_q[4:0]))) begin
        flags_d[FlagExtended] = 1'b0;
      end
      if ((pos_q >= PosW'(ScreamOffset)) && (pos_q < PosW'(ScreamOffset + ShortSigLen))
          && (b != scream_byte(idx))) begin
        flags_d[FlagScream] = 1'b0;
      end
      if (pos_q == PosW'(VersionOffset)) begin
        ver_d = (b == VersionValue);
      end
      if (tail_wr) begin
        tail_d[idx] = b;
      end
      pos_d = pos_q + PosW'(1);
    end
  end

  // protracker tail: two digits 1..32 then "CH", a digit then "CHN", or "M.K."
  assign chan_cnt = 7'(tail_d[0][3:0]) * 7'd10 + 7'(tail_d[1][3:0]);

  always_comb begin
    tail_hit = 1'b0;
    if (is_digit(tail_d[0]) && is_digit(tail_d[1]) && (tail_d[2] == "C")
        && (tail_d[3] == "H") && (chan_cnt != 7'd0)
        && (chan_cnt <= 7'(MaxChannels))) begin
      tail_hit = 1'b1;
    end
    if (is_digit(tail_d[0]) && (tail_d[1] == "C") && (tail_d[2] == "H")
        && (tail_d[3] == "N")) begin
      tail_hit = 1'b1;
    end
    if ((tail_d[0] == "M") && (tail_d[1] == ".") && (tail_d[2] == "K")
        && (tail_d[3] == ".")) begin
      tail_hit = 1'b1;
    end
  end

  // every check also needs the file long enough to hold its signature
  assign hit =
      ((pos_d >= PosW'(ShortSigLen)) && flags_d[FlagImpulse])
   || ((pos_d >= PosW'(ShortSigLen)) && flags_d[FlagMulti])
   || ((pos_d >= PosW'(ExtSigLen)) && flags_d[FlagExtended])
   || ((pos_d >= PosW'(ScreamOffset + ShortSigLen)) && flags_d[FlagScream] && ver_d)
   || ((pos_d >= PosW'(PosLimit)) && tail_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      flags_q <= '1;
      ver_q   <= 1'b0;
    end else if (s1_adv) begin
      if (s1_item_q.last_byte) begin
        // end of file: back to reset for the next file
        pos_q   <= '0;
        flags_q <= '1;
        ver_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        flags_q <= flags_d;
        ver_q   <= ver_d;
      end
    end
  end

  // tail window, only read once all four entries of this file are written
  always_ff @(posedge clk_i) begin
    if (s1_adv && tail_wr) begin
      tail_q[idx] <= b;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_item_q.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && s1_item_q.last_byte) begin
      out_ident_q <= hit;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.identified = out_ident_q;

endmodule

// ===== design/tmfs_checker.sv =====
// port-level checker for the tracker module format sniffer
// depends on nothing but the top level's ports; bound to the top level below
module tmfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_ident_i
);

  logic       last_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc  = out_valid_i && out_ready_i;

  // last bytes taken whose result word is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (last_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !last_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // a stalled result word holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ident_i))
    else $error("result word changed while stalled");

  // no result word without a last byte behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result word without a last byte");

  // input register and result register hold at most two pending files
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more pending files than pipeline slots");

  // with both slots full the input must stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 && !out_ready_i |-> !in_ready_i)
    else $error("input taken with a full pipeline");

endmodule

bind tracker_module_format_sniffer tmfs_checker u_tmfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_ident_i (out_o.identified)
);

// ===== tb/sv/tracker_module_format_sniffer_tb.sv =====
// self-checking testbench for the tracker module format sniffer
// streams byte words as files and checks every verdict word against its own predictor
// depends on tmfs_pkg, the channel interfaces in tmfs_if.sv and the sniffer top level
module tracker_module_format_sniffer_tb;
  import tmfs_pkg::*;

  // signature strings, packed so that the first byte of the file sits in the top byte
  localparam logic [8*ShortSigLen-1:0] ImpulseSig = "IMPM";
  localparam logic [8*ShortSigLen-1:0] MultiSig   = {"MTM", 8'h10};
  localparam logic [8*ShortSigLen-1:0] ScreamSig  = "SCRM";
  localparam logic [8*ExtSigLen-1:0]   ExtendedSig = "Extended Module: ";
  localparam logic [8*ShortSigLen-1:0] PlainTag   = "M.K.";

  localparam int CycleLimit  = 300000;
  localparam int ShortBudget = 550;   // words in short files over the four idling phases
  localparam int DrainCycles = 10;

  typedef enum int {
    FileNoise,
    FileImpulse,
    FileExtended,
    FileMulti,
    FileScream,
    FileTracker
  } file_kind_e;

  // scoreboard: follows the file as bytes are accepted and queues one verdict per file
  class sniff_scoreboard;
    logic [PosW-1:0] file_offset;
    logic [3:0]      sig_alive;
    logic            version_seen;
    logic [7:0]      tag_bytes [4];
    bit              expected_verdicts [$];
    int              errors;
    int              files_seen;
    int              files_hit;

    function new();
      errors = 0;
      files_seen = 0;
      files_hit = 0;
      start_file();
    endfunction

    function void start_file();
      file_offset = '0;
      sig_alive = 4'hF;
      version_seen = 1'b0;
      foreach (tag_bytes[i]) tag_bytes[i] = 8'h00;
    endfunction

    function bit channel_tag_ok();
      bit d0, d1;
      int channels;
      d0 = (tag_bytes[0] >= "0") && (tag_bytes[0] <= "9");
      d1 = (tag_bytes[1] >= "0") && (tag_bytes[1] <= "9");
      if (d0 && d1 && tag_bytes[2] == "C" && tag_bytes[3] == "H") begin
        channels = (tag_bytes[0] - "0") * 10 + (tag_bytes[1] - "0");
        if (channels > 0 && channels <= MaxChannels) return 1'b1;
      end
      if (d0 && tag_bytes[1] == "C" && tag_bytes[2] == "H" && tag_bytes[3] == "N") return 1'b1;
      return {tag_bytes[0], tag_bytes[1], tag_bytes[2], tag_bytes[3]} == PlainTag;
    endfunction

    function void note_byte(logic [7:0] data, logic last_flag);
      int p;
      int flen;
      bit hit;
      p = file_offset;
      if (p < PosLimit) begin
        if (p < ShortSigLen) begin
          if (data != ImpulseSig[8*(ShortSigLen-1-p) +: 8]) sig_alive[FlagImpulse] = 1'b0;
          if (data != MultiSig[8*(ShortSigLen-1-p) +: 8]) sig_alive[FlagMulti] = 1'b0;
        end
        if (p < ExtSigLen && data != ExtendedSig[8*(ExtSigLen-1-p) +: 8])
          sig_alive[FlagExtended] = 1'b0;
        if (p >= ScreamOffset && p < ScreamOffset + ShortSigLen &&
            data != ScreamSig[8*(ScreamOffset+ShortSigLen-1-p) +: 8])
          sig_alive[FlagScream] = 1'b0;
        if (p == VersionOffset) version_seen = (data == VersionValue);
        if (p >= TailStart) tag_bytes[p - TailStart] = data;
        file_offset = file_offset + 1'b1;
      end
      if (!last_flag) return;
      flen = file_offset;
      hit = 1'b0;
      if (flen >= ShortSigLen && sig_alive[FlagImpulse]) hit = 1'b1;
      if (flen >= ShortSigLen && sig_alive[FlagMulti]) hit = 1'b1;
      if (flen >= ExtSigLen && sig_alive[FlagExtended]) hit = 1'b1;
      if (flen >= ScreamOffset + ShortSigLen && sig_alive[FlagScream] && version_seen)
        hit = 1'b1;
      if (flen >= PosLimit && channel_tag_ok()) hit = 1'b1;
      expected_verdicts.push_back(hit);
      files_seen++;
      if (hit) files_hit++;
      start_file();
    endfunction

    function void check_verdict(logic identified);
      bit want;
      if (expected_verdicts.size() == 0) begin
        $error("identified: no verdict expected, got %0b", identified);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (identified !== want) begin
        $error("identified: expected %0b, got %0b", want, identified);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_request;
  int   hold_left;
  int   short_words;
  int   long_files;
  logic [7:0] file_bytes [$];
  sniff_scoreboard sb;

  tmfs_in_if  in_ch ();
  tmfs_out_if out_ch ();

  tracker_module_format_sniffer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop in case the block hangs on a handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: check each accepted word, then pick ready for the next edge;
  // a hold request from the stimulus keeps ready low until its count runs out
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_verdict(out_ch.identified);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one byte word, with random idle cycles ahead of it, and wait for the handshake
  task automatic send_word(input logic [7:0] data, input logic last_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= data;
    in_ch.last_byte  <= last_flag;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_byte(data, last_flag);
  endtask

  // stream the whole file, marking its final byte
  task automatic send_file();
    foreach (file_bytes[i]) send_word(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // channel tag at 1080..1083: good and bad channel counts, the N form, the plain tag, noise
  task automatic place_tag();
    int n;
    logic [8*ShortSigLen-1:0] tag;
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(39);
        tag = {8'("0" + n / 10), 8'("0" + n % 10), "CH"};
      end
      1: tag = {8'("0" + $urandom_range(9)), "CHN"};
      2: tag = PlainTag;
      default: tag = $urandom;
    endcase
    for (int i = 0; i < ShortSigLen; i++)
      if (TailStart + i < file_bytes.size())
        file_bytes[TailStart + i] = tag[8*(ShortSigLen-1-i) +: 8];
  endtask

  // random body with the kind's signature laid over it (none for noise); one byte in four files gets broken
  task automatic make_file(input file_kind_e kind);
    int flen;
    int reach;
    case (kind)
      FileImpulse, FileMulti: flen = $urandom_range(1, 10);
      FileExtended:           flen = $urandom_range(14, 22);
      FileScream:             flen = $urandom_range(42, 52);
      FileTracker:            flen = $urandom_range(TailStart, PosLimit + 6);
      default:                flen = $urandom_range(1, 40);
    endcase
    file_bytes.delete();
    repeat (flen) file_bytes.push_back($urandom);
    for (int i = 0; i < flen; i++) begin
      if (kind == FileImpulse && i < ShortSigLen)
        file_bytes[i] = ImpulseSig[8*(ShortSigLen-1-i) +: 8];
      if (kind == FileMulti && i < ShortSigLen)
        file_bytes[i] = MultiSig[8*(ShortSigLen-1-i) +: 8];
      if (kind == FileExtended && i < ExtSigLen)
        file_bytes[i] = ExtendedSig[8*(ExtSigLen-1-i) +: 8];
      if (kind == FileScream && i >= ScreamOffset && i < ScreamOffset + ShortSigLen)
        file_bytes[i] = ScreamSig[8*(ScreamOffset+ShortSigLen-1-i) +: 8];
    end
    if (kind == FileScream && flen > VersionOffset && $urandom_range(3) != 0)
      file_bytes[VersionOffset] = VersionValue;
    if (kind == FileTracker) begin
      // long files also carry a short prefix signature now and then
      if ($urandom_range(3) == 0)
        for (int i = 0; i < ShortSigLen; i++)
          file_bytes[i] = ImpulseSig[8*(ShortSigLen-1-i) +: 8];
      place_tag();
    end
    if ($urandom_range(3) == 0) begin
      reach = (flen < ScreamOffset + ShortSigLen) ? flen : ScreamOffset + ShortSigLen;
      if (kind == FileTracker && $urandom_range(1) == 1)
        file_bytes[$urandom_range(flen - 1, TailStart)] = $urandom;
      else
        file_bytes[$urandom_range(reach - 1)] = $urandom;
    end
  endtask

  function automatic file_kind_e pick_short_kind();
    case ($urandom_range(9))
      0, 1:    return FileNoise;
      2, 3:    return FileImpulse;
      4:       return FileExtended;
      5, 6:    return FileMulti;
      default: return FileScream;
    endcase
  endfunction

  initial begin
    sb = new();
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    short_words = 0;
    long_files = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte_value = 8'h00;
    in_ch.last_byte = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short prefix hits, a file one byte too short, byte extremes as
    // one-byte files, a broken multitracker tag, an unmarked byte ahead of a last one
    file_bytes = '{"I", "M", "P", "M"};
    send_file();
    file_bytes = '{"I", "M", "P"};
    send_file();
    file_bytes = '{8'h00};
    send_file();
    file_bytes = '{8'hFF};
    send_file();
    file_bytes = '{"M", "T", "M", 8'h10};
    send_file();
    file_bytes = '{"M", "T", "M", 8'h11};
    send_file();
    file_bytes = '{8'hAA, 8'h55};
    send_file();

    // random files over four idling phases: none, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      while (short_words < ShortBudget * (phase + 1) / 4) begin
        make_file(pick_short_kind());
        short_words += file_bytes.size();
        send_file();
      end
      // one long file per phase reaches into the channel tag, and past 1084 bytes the saturated counter
      make_file(FileTracker);
      long_files++;
      send_file();
    end

    // back-pressure: the receiver holds off while tiny files keep coming, so the
    // result register stays full and the input side has to stall
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 200;
    repeat (24) begin
      make_file(pick_short_kind());
      if (file_bytes.size() > 2) file_bytes = file_bytes[0:1];
      send_file();
    end
    in_ch.valid <= 1'b0;

    // drain, then keep watching the pipeline for any stray word
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d files (%0d identified, %0d long ones past the channel tag)",
             sb.files_seen, sb.files_hit, long_files);
    $display("idling phases, receiver hold-off and %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
